@@ rtl/negacyclic_monomial_rotate_unit_macros.svh @@
// Assertion macros for the negacyclic monomial rotate unit.
// Included by files that carry concurrent checks; needs a signal named clock and reset.
`ifndef NEGACYCLIC_MONOMIAL_ROTATE_UNIT_MACROS_SVH
`define NEGACYCLIC_MONOMIAL_ROTATE_UNIT_MACROS_SVH

// a holds -> b holds in the same cycle
`define NMR_ASSERT_SAME(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("same-cycle check failed");

// a holds -> b holds in the next cycle
`define NMR_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/nmr_pkg.sv @@
// Shared constants, codes and control structs of the monomial rotate unit.
// No dependencies; used by the interfaces, the rotate unit and the reduction module.
package nmr_pkg;

   localparam int RING_DEGREE = 1024;  // power of two, at most 1024
   localparam int ADDR_W      = $clog2(RING_DEGREE);
   localparam int COEF_W      = 63;
   localparam int INDEX_W     = 10;
   localparam int ROT_W       = 11;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int COUNT_W     = $clog2(COEF_W + 1);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   localparam logic [1:0] REG_MODULUS  = 2'd0;
   localparam logic [1:0] REG_ROTATION = 2'd1;
   localparam logic [1:0] REG_MODE     = 2'd2;

   localparam logic [COEF_W-1:0] MODULUS_RESET  = COEF_W'(65537);
   localparam logic [ROT_W-1:0]  ROTATION_RESET = '0;
   localparam logic              MODE_RESET     = 1'b1;

   typedef struct packed {
      logic start;
      logic negate;
      logic ack;
   } nmr_red_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } nmr_red_sts_type;

endpackage

@@ rtl/nmr_req_if.sv @@
// Request channel: valid/ready handshake carrying one write or read request.
// Depends on nmr_pkg for field widths.
interface nmr_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [nmr_pkg::INDEX_W-1:0] coef_index;
   logic [nmr_pkg::COEF_W-1:0]  coef_value;

   modport source (output valid, output req_type, output coef_index, output coef_value,
                   input ready);
   modport sink   (input valid, input req_type, input coef_index, input coef_value,
                   output ready);
endinterface

@@ rtl/nmr_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one rotated coefficient.
// Depends on nmr_pkg for field widths.
interface nmr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [nmr_pkg::COEF_W-1:0] rotated_coef;

   modport source (output valid, output rotated_coef, input ready);
   modport sink   (input valid, input rotated_coef, output ready);
endinterface

@@ rtl/negacyclic_monomial_rotate_unit.sv @@
// Write request: no busy state; the next request is taken the cycle after.
// Read request: response valid after the FETCH and REDUCE states; no request is taken meanwhile.
// The read time is set by the bit-serial x mod q unit (63 steps) plus RAM read and fixup.
// A pending response does not block writes; it blocks only the next read's completion.
// Reset clears control and config registers; the coefficient RAM is not cleared.
module negacyclic_monomial_rotate_unit (
   input  logic                              clock,
   input  logic                              reset,
   nmr_req_if.sink                           req_chan,
   nmr_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [nmr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [nmr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [nmr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

`include "negacyclic_monomial_rotate_unit_macros.svh"

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_REDUCE} top_state_type;

   top_state_type                  state_ff, state_in;
   logic [nmr_pkg::COEF_W-1:0]     modulus_ff;
   logic [nmr_pkg::ROT_W-1:0]      rotation_ff;
   logic                           mode_ff;
   logic                           negate_ff, negate_in;
   logic                           oob_ff, oob_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [nmr_pkg::COEF_W-1:0]     rsp_coef_ff, rsp_coef_in;

   logic                           req_accept;
   logic                           csr_write;
   logic [1:0]                     csr_index;
   logic [nmr_pkg::ADDR_W-1:0]     shift;
   logic [nmr_pkg::ADDR_W-1:0]     index;
   logic [nmr_pkg::ADDR_W-1:0]     src_addr;
   logic                           half_turn;
   logic                           wrapped;
   logic                           ram_wr_en;
   logic                           ram_rd_en;
   logic [nmr_pkg::COEF_W-1:0]     ram_rd_data;
   logic [nmr_pkg::COEF_W-1:0]     red_x;
   logic [nmr_pkg::COEF_W-1:0]     red_result;
   nmr_pkg::nmr_red_ctl_type       red_ctl;
   nmr_pkg::nmr_red_sts_type       red_sts;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[nmr_pkg::CSR_ADDR_W-1:3];

   always_comb begin
      case (csr_index)
         nmr_pkg::REG_MODULUS:  csr_prdata = {1'b0, modulus_ff};
         nmr_pkg::REG_ROTATION: csr_prdata = nmr_pkg::CSR_DATA_W'(rotation_ff);
         nmr_pkg::REG_MODE:     csr_prdata = nmr_pkg::CSR_DATA_W'(mode_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= nmr_pkg::MODULUS_RESET;
         rotation_ff <= nmr_pkg::ROTATION_RESET;
         mode_ff     <= nmr_pkg::MODE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            nmr_pkg::REG_MODULUS:  modulus_ff  <= csr_pwdata[nmr_pkg::COEF_W-1:0];
            nmr_pkg::REG_ROTATION: rotation_ff <= csr_pwdata[nmr_pkg::ROT_W-1:0];
            nmr_pkg::REG_MODE:     mode_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // address math: ring degree is a power of two, so r mod N and r mod 2N are bit fields
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign index          = req_chan.coef_index[nmr_pkg::ADDR_W-1:0];
   assign shift          = rotation_ff[nmr_pkg::ADDR_W-1:0];
   assign half_turn      = rotation_ff[nmr_pkg::ADDR_W];
   assign wrapped        = (index < shift);
   assign src_addr       = index - shift;
   assign oob_in         = (32'(req_chan.coef_index) >= nmr_pkg::RING_DEGREE);
   assign negate_in      = mode_ff && (half_turn ^ wrapped);

   assign ram_wr_en = req_accept && (req_chan.req_type == nmr_pkg::REQ_WRITE) && !oob_in;
   assign ram_rd_en = req_accept && (req_chan.req_type == nmr_pkg::REQ_READ);

   nmr_coef_ram #(
      .DEPTH (nmr_pkg::RING_DEGREE),
      .WIDTH (nmr_pkg::COEF_W)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (index),
      .wr_data (req_chan.coef_value),
      .rd_en   (ram_rd_en),
      .rd_addr (src_addr),
      .rd_data (ram_rd_data)
   );

   // out-of-range reads reduce a zero, which comes out as zero
   assign red_x = oob_ff ? '0 : ram_rd_data;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_coef_in    = rsp_coef_ff;
      red_ctl.start  = 1'b0;
      red_ctl.negate = negate_ff;
      red_ctl.ack    = 1'b0;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (ram_rd_en) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            red_ctl.start = 1'b1;
            state_in      = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (red_sts.done && (!rsp_valid_ff || rsp_chan.ready)) begin
               red_ctl.ack  = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_coef_in  = red_result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_coef_ff <= rsp_coef_in;
      if (ram_rd_en) begin
         negate_ff <= negate_in;
         oob_ff    <= oob_in;
      end
   end

   nmr_modred u_modred (
      .clock  (clock),
      .reset  (reset),
      .ctl    (red_ctl),
      .x      (red_x),
      .q      (modulus_ff),
      .sts    (red_sts),
      .result (red_result)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.rotated_coef = rsp_coef_ff;

   `NMR_ASSERT_NEXT(a_read_blocks_next, ram_rd_en, !req_chan.ready)
   `NMR_ASSERT_SAME(a_done_only_reducing, red_sts.done, state_ff == ST_REDUCE)
   `NMR_ASSERT_SAME(a_rsp_from_reducer, $rose(rsp_valid_ff), $past(red_sts.done))
   `NMR_ASSERT_SAME(a_start_when_free, red_ctl.start, !red_sts.busy)

endmodule

@@ rtl/nmr_coef_ram.sv @@
// Single-clock coefficient RAM, one write and one read port, registered read.
// Generic; no package dependency.
module nmr_coef_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 63
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/nmr_modred.sv @@
// Bit-serial modular reduction x mod q with optional negation (q - (x mod q), zero kept).
// One quotient bit per cycle; depends on nmr_pkg.
module nmr_modred (
   input  logic                          clock,
   input  logic                          reset,
   input  nmr_pkg::nmr_red_ctl_type      ctl,
   input  logic [nmr_pkg::COEF_W-1:0]    x,
   input  logic [nmr_pkg::COEF_W-1:0]    q,
   output nmr_pkg::nmr_red_sts_type      sts,
   output logic [nmr_pkg::COEF_W-1:0]    result
);

   typedef enum logic [1:0] {RS_IDLE, RS_DIVIDE, RS_FIX, RS_DONE} red_state_type;

   red_state_type                  state_ff, state_in;
   logic [nmr_pkg::COEF_W-1:0]     dividend_ff, dividend_in;
   logic [nmr_pkg::COEF_W-1:0]     modulus_ff, modulus_in;
   logic [nmr_pkg::COEF_W-1:0]     rem_ff, rem_in;
   logic [nmr_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                           negate_ff, negate_in;
   logic [nmr_pkg::COEF_W:0]       trial;

   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      modulus_in  = modulus_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      negate_in   = negate_ff;
      trial       = {rem_ff, dividend_ff[nmr_pkg::COEF_W-1]};
      case (state_ff)
         RS_IDLE: begin
            if (ctl.start) begin
               dividend_in = x;
               modulus_in  = q;
               negate_in   = ctl.negate;
               rem_in      = '0;
               count_in    = nmr_pkg::COUNT_W'(nmr_pkg::COEF_W);
               state_in    = RS_DIVIDE;
            end
         end
         RS_DIVIDE: begin
            // restoring step: remainder stays below q, so trial fits one extra bit
            if (trial >= {1'b0, modulus_ff}) begin
               rem_in = nmr_pkg::COEF_W'(trial - {1'b0, modulus_ff});
            end else begin
               rem_in = trial[nmr_pkg::COEF_W-1:0];
            end
            dividend_in = {dividend_ff[nmr_pkg::COEF_W-2:0], 1'b0};
            count_in    = count_ff - 1'b1;
            if (count_ff == nmr_pkg::COUNT_W'(1)) begin
               state_in = RS_FIX;
            end
         end
         RS_FIX: begin
            // zero modulus yields zero; negation keeps zero
            if (modulus_ff == '0) begin
               rem_in = '0;
            end else if (negate_ff && rem_ff != '0) begin
               rem_in = modulus_ff - rem_ff;
            end
            state_in = RS_DONE;
         end
         RS_DONE: begin
            if (ctl.ack) begin
               state_in = RS_IDLE;
            end
         end
         default: state_in = RS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dividend_ff <= dividend_in;
      modulus_ff  <= modulus_in;
      rem_ff      <= rem_in;
      count_ff    <= count_in;
      negate_ff   <= negate_in;
   end

   assign sts.busy = (state_ff != RS_IDLE);
   assign sts.done = (state_ff == RS_DONE);
   assign result   = rem_ff;

endmodule
